>>> hw/rtl/operand_stack_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Operand stack engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OPERAND_STACK_ENGINE_UNIT_MACROS_SVH
`define OPERAND_STACK_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define OSE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("operand stack engine check failed");

// Next-cycle implication.
`define OSE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("operand stack engine check failed");

`endif

>>> hw/rtl/ose_pkg.sv
// ----------------------------------------------------------------------------
// Operand stack engine package
// Widths, command and status codes, and the controller-to-datapath types.
// ----------------------------------------------------------------------------
package ose_pkg;

  localparam int WORD_W        = 64;
  localparam int FUNC_W        = 3;
  localparam int COUNT_W       = 8;
  localparam int STATUS_W      = 3;
  localparam int DEFAULT_DEPTH = 64;

  // Command codes; the two remaining codes are unknown commands.
  localparam logic [FUNC_W-1:0] FN_PUSH  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PEEK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DUP   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SWAP  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DUMP  = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTENOUGH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;

  // Read address source.
  typedef enum logic [1:0] {
    RD_TOP,
    RD_BELOW,
    RD_PTR
  } rd_sel_t;

  // Write address and data source.
  typedef enum logic [1:0] {
    WR_PUSH,
    WR_DUP,
    WR_SWAP_TOP,
    WR_SWAP_BELOW
  } wr_sel_t;

  // Depth register update.
  typedef enum logic [1:0] {
    DOP_KEEP,
    DOP_INC,
    DOP_CLEAR
  } depth_op_t;

  typedef struct packed {
    logic                latch;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                wr_en;
    wr_sel_t             wr_sel;
    depth_op_t           depth_op;
    logic                ptr_load;
    logic                hold_load;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_entry;
  } ose_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              full;
    logic              two;
    logic              count_zero;
    logic              out_free;
    logic              pending;
    logic              more;
  } ose_stat_t;

endpackage

>>> hw/rtl/ose_ram.sv
// ----------------------------------------------------------------------------
// Operand stack engine RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ose_ram
  import ose_pkg::*;
#(
  parameter int WIDTH = WORD_W,
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/ose_ctrl.sv
// ----------------------------------------------------------------------------
// Operand stack engine controller
// Sequences each command over the datapath, one command at a time.
// ----------------------------------------------------------------------------
module ose_ctrl
  import ose_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ose_stat_t stat,
  output ose_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DUP_WR,
    S_SW_RD2,
    S_SW_WR1,
    S_SW_WR2,
    S_SHOW
  } state_t;

  state_t state;
  state_t state_next;

  logic show_load;

  assign in_ready  = (state == S_IDLE);
  assign show_load = stat.pending && stat.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.func)
          FN_PUSH: begin
            if (stat.out_free) begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_PUSH;
                cmd.depth_op = DOP_INC;
              end
              state_next = S_IDLE;
            end
          end
          FN_PEEK: begin
            if (stat.empty || stat.count_zero) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = stat.empty ? ST_EMPTY : ST_OK;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.ptr_load = 1'b1;
              state_next   = S_SHOW;
            end
          end
          FN_DUP: begin
            if (stat.empty || stat.full) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = stat.empty ? ST_EMPTY : ST_FULL;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
              state_next = S_DUP_WR;
            end
          end
          FN_SWAP: begin
            if (!stat.two) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_NOTENOUGH;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
              state_next = S_SW_RD2;
            end
          end
          FN_CLEAR: begin
            if (stat.out_free) begin
              cmd.out_load = 1'b1;
              cmd.depth_op = DOP_CLEAR;
              state_next   = S_IDLE;
            end
          end
          FN_DUMP: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.ptr_load = 1'b1;
              state_next   = S_SHOW;
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_UNKNOWN;
              state_next     = S_IDLE;
            end
          end
        endcase
      end
      S_DUP_WR: begin
        if (stat.out_free) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_DUP;
          cmd.depth_op = DOP_INC;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SW_RD2: begin
        cmd.hold_load = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_BELOW;
        state_next    = S_SW_WR1;
      end
      S_SW_WR1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SWAP_TOP;
        state_next = S_SW_WR2;
      end
      S_SW_WR2: begin
        if (stat.out_free) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_SWAP_BELOW;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SHOW: begin
        // Keep one read in flight: issue the next read when the word in
        // the read register is free to move into the output register.
        cmd.rd_sel    = RD_PTR;
        cmd.rd_en     = stat.more && (!stat.pending || stat.out_free);
        cmd.out_load  = show_load;
        cmd.out_entry = 1'b1;
        if (show_load && !stat.more) begin
          if (stat.func == FN_DUMP) begin
            cmd.depth_op = DOP_CLEAR;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/ose_datapath.sv
// ----------------------------------------------------------------------------
// Operand stack engine datapath
// Command register, stack RAM, depth and read pointer, and output register.
// ----------------------------------------------------------------------------
module ose_datapath
  import ose_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  ose_cmd_t            cmd,
  output ose_stat_t           stat,
  input  logic [FUNC_W-1:0]   func,
  input  logic [WORD_W-1:0]   value,
  input  logic [COUNT_W-1:0]  count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic                has_value,
  output logic [WORD_W-1:0]   value_res,
  output logic                last
);

  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH + 1);
  localparam int CW = (DW > COUNT_W) ? DW : COUNT_W;
  localparam logic [DW-1:0] FULL_LEVEL = DW'(DEPTH);

  logic [FUNC_W-1:0]  cmd_func;
  logic [WORD_W-1:0]  cmd_value;
  logic [COUNT_W-1:0] cmd_count;
  logic [DW-1:0]      depth;
  logic [DW-1:0]      rd_ptr;
  logic               pending;
  logic [WORD_W-1:0]  hold;
  logic [WORD_W-1:0]  rdata;

  logic [DW-1:0]      top_idx;
  logic [DW-1:0]      below_idx;
  logic [CW-1:0]      shown;
  logic [DW-1:0]      first_peek;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               out_free;
  logic               more;

  assign top_idx   = depth - DW'(1);
  assign below_idx = depth - DW'(2);
  assign out_free  = !out_valid || out_ready;
  assign more      = (rd_ptr != depth);

  // Peek shows the top min(count, depth) entries, oldest first.
  assign shown = (CW'(cmd_count) > CW'(depth)) ? CW'(depth) : CW'(cmd_count);
  assign first_peek = depth - shown[DW-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_TOP:   rd_addr = top_idx[AW-1:0];
      RD_BELOW: rd_addr = below_idx[AW-1:0];
      RD_PTR:   rd_addr = rd_ptr[AW-1:0];
      default:  rd_addr = rd_ptr[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_PUSH: begin
        wr_addr = depth[AW-1:0];
        wr_data = cmd_value;
      end
      WR_DUP: begin
        wr_addr = depth[AW-1:0];
        wr_data = rdata;
      end
      WR_SWAP_TOP: begin
        wr_addr = top_idx[AW-1:0];
        wr_data = rdata;
      end
      WR_SWAP_BELOW: begin
        wr_addr = below_idx[AW-1:0];
        wr_data = hold;
      end
      default: begin
        wr_addr = depth[AW-1:0];
        wr_data = cmd_value;
      end
    endcase
  end

  ose_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  always_comb begin
    stat.func       = cmd_func;
    stat.empty      = (depth == '0);
    stat.full       = (depth == FULL_LEVEL);
    stat.two        = (depth >= DW'(2));
    stat.count_zero = (cmd_count == '0);
    stat.out_free   = out_free;
    stat.pending    = pending;
    stat.more       = more;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_func  <= func;
      cmd_value <= value;
      cmd_count <= count;
    end
    if (cmd.hold_load) begin
      hold <= rdata;
    end
    if (cmd.out_load) begin
      status    <= cmd.out_status;
      has_value <= cmd.out_entry;
      value_res <= cmd.out_entry ? rdata : '0;
      last      <= cmd.out_entry ? !more : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      rd_ptr    <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (cmd.depth_op)
        DOP_INC:   depth <= depth + DW'(1);
        DOP_CLEAR: depth <= '0;
        default:   depth <= depth;
      endcase

      if (cmd.ptr_load) begin
        rd_ptr <= (cmd_func == FN_DUMP) ? '0 : first_peek;
      end else if (cmd.rd_en && (cmd.rd_sel == RD_PTR)) begin
        rd_ptr <= rd_ptr + DW'(1);
      end

      if (cmd.latch) begin
        pending <= 1'b0;
      end else if (cmd.rd_en && (cmd.rd_sel == RD_PTR)) begin
        pending <= 1'b1;
      end else if (cmd.out_load) begin
        pending <= 1'b0;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/operand_stack_engine_unit.sv
// ----------------------------------------------------------------------------
// Operand stack engine
// LIFO stack of 64-bit words with push, peek, duplicate, swap, clear and dump.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel (func, value, count) is one
// command. The block answers on the output channel with one or more result
// transfers (status, has_value, value_res, last); last marks the final
// result of a command. Peek and dump return one result per entry shown,
// oldest first, or one status result if none is shown; every other command
// returns a single status result. Commands run one at a time: in_ready is
// high only while the controller waits for a command. Duplicate reads the
// top entry, then writes the copy; swap reads the top and the entry below,
// then writes both back in turn through the single write port of the stack
// RAM. Peek and dump load the read pointer, issue the first registered RAM
// read, then move one entry per cycle to the output while out_ready is high.
// A result is visible on the cycle after it is produced and stays held while
// out_ready is low; the sequence simply pauses until the receiver takes it.
// Reset empties the stack (the depth goes to zero) and drops any pending
// result; the stored words themselves are not cleared.
// ----------------------------------------------------------------------------
module operand_stack_engine_unit
  import ose_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [WORD_W-1:0]   value,
  input  logic [COUNT_W-1:0]  count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic                has_value,
  output logic [WORD_W-1:0]   value_res,
  output logic                last
);

  // Commands from the controller to the datapath, and status back.
  ose_cmd_t  cmd;
  ose_stat_t stat;

  // The controller owns sequencing; it accepts a command only when idle.
  ose_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the latched command, the stack RAM, the depth, the
  // read pointer for peek and dump, and the output register.
  ose_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .func      (func),
    .value     (value),
    .count     (count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .has_value (has_value),
    .value_res (value_res),
    .last      (last)
  );

endmodule

>>> hw/rtl/ose_checker.sv
// ----------------------------------------------------------------------------
// Operand stack engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "operand_stack_engine_unit_macros.svh"

module ose_checker
  import ose_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic                has_value,
  input logic [WORD_W-1:0]   value_res,
  input logic                last
);

  logic [STATUS_W+WORD_W+1:0] out_fields;

  assign out_fields = {status, has_value, value_res, last};

  // A stalled result holds its payload.
  `OSE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))

  // A status-only result carries a zero word and ends its command.
  `OSE_ASSERT_IMP(a_status_only, out_valid && !has_value, (value_res == '0) && last)

  // Entries are only shown by successful peek or dump.
  `OSE_ASSERT_IMP(a_entry_ok, out_valid && has_value, status == ST_OK)

  // Commands run one at a time: a command transfer closes the input.
  `OSE_ASSERT_NXT(a_one_cmd, in_valid && in_ready, !in_ready)

endmodule

bind operand_stack_engine_unit ose_checker u_ose_checker (.*);
